// ----- rtl/bbo_pkg.sv -----
// Shared types, constants and helper functions for the bounding box border overlay.
package bbo_pkg;

  localparam int FRAME_W = 13;
  localparam int COORD_W = 13;
  localparam int CLS_W   = 8;
  localparam int PIX_W   = 12;
  localparam int CH_W    = 8;
  localparam int PAL_W   = 3;
  localparam int CRD_W   = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_PIXEL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } color_t;

  localparam color_t PAL_GREEN   = '{blue: 8'd0,   green: 8'd255, red: 8'd0};
  localparam color_t PAL_RED     = '{blue: 8'd0,   green: 8'd0,   red: 8'd255};
  localparam color_t PAL_BLUE    = '{blue: 8'd255, green: 8'd0,   red: 8'd0};
  localparam color_t PAL_YELLOW  = '{blue: 8'd0,   green: 8'd255, red: 8'd255};
  localparam color_t PAL_MAGENTA = '{blue: 8'd255, green: 8'd0,   red: 8'd255};
  localparam color_t PAL_CYAN    = '{blue: 8'd255, green: 8'd255, red: 8'd0};

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] bottom;
    logic [PAL_W-1:0]          pal;
  } box_t;

  typedef struct packed {
    logic [1:0]                mode;
    logic signed [COORD_W-1:0] box_left;
    logic signed [COORD_W-1:0] box_top;
    logic signed [COORD_W-1:0] box_right;
    logic signed [COORD_W-1:0] box_bottom;
    logic [CLS_W-1:0]          class_number;
    logic [PIX_W-1:0]          pixel_col;
    logic [PIX_W-1:0]          pixel_row;
    color_t                    pix;
  } in_item_t;

  // Class id modulo six: the quotient comes from a multiply by 171/1024,
  // which is exact for every 8-bit class id.
  function automatic logic [PAL_W-1:0] pal_index(input logic [CLS_W-1:0] cls);
    logic [15:0] prod;
    logic [5:0]  quo;
    logic [7:0]  rem;
    prod = {8'd0, cls} * 16'd171;
    quo  = prod[15:10];
    rem  = cls - 8'({2'd0, quo} * 8'd6);
    return rem[PAL_W-1:0];
  endfunction

  function automatic color_t pal_color(input logic [PAL_W-1:0] idx);
    color_t c;
    case (idx)
      3'd0:    c = PAL_GREEN;
      3'd1:    c = PAL_RED;
      3'd2:    c = PAL_BLUE;
      3'd3:    c = PAL_YELLOW;
      3'd4:    c = PAL_MAGENTA;
      3'd5:    c = PAL_CYAN;
      default: c = PAL_GREEN;
    endcase
    return c;
  endfunction

  function automatic logic signed [CRD_W-1:0] sx_coord(input logic signed [COORD_W-1:0] v);
    return {{(CRD_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

endpackage

// ----- rtl/bbo_in_if.sv -----
// Input channel interface: one word is a command or a pixel.
interface bbo_in_if import bbo_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                mode;
  logic signed [COORD_W-1:0] box_left;
  logic signed [COORD_W-1:0] box_top;
  logic signed [COORD_W-1:0] box_right;
  logic signed [COORD_W-1:0] box_bottom;
  logic [CLS_W-1:0]          class_number;
  logic [PIX_W-1:0]          pixel_col;
  logic [PIX_W-1:0]          pixel_row;
  logic [CH_W-1:0]           in_blue;
  logic [CH_W-1:0]           in_green;
  logic [CH_W-1:0]           in_red;

  modport source (output valid, mode, box_left, box_top, box_right, box_bottom,
                  class_number, pixel_col, pixel_row, in_blue, in_green, in_red,
                  input ready);
  modport sink (input valid, mode, box_left, box_top, box_right, box_bottom,
                class_number, pixel_col, pixel_row, in_blue, in_green, in_red,
                output ready);
endinterface

// ----- rtl/bbo_out_if.sv -----
// Result channel interface: one word is an output pixel.
interface bbo_out_if import bbo_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_blue;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_red;
  logic            on_border;

  modport source (output valid, out_blue, out_green, out_red, on_border, input ready);
  modport sink (input valid, out_blue, out_green, out_red, on_border, output ready);
endinterface

// ----- rtl/bbo_cfg_if.sv -----
// Configuration write channel interface.
interface bbo_cfg_if import bbo_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FRAME_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/bbo_box_lane.sv -----
// One box table entry with its clamp and border compare logic.
module bbo_box_lane import bbo_pkg::*; #(
  parameter int BORDER_WIDTH = 2
) (
  input  logic               clk,
  input  logic               wr_en,
  input  box_t               wr_box,
  input  logic [FRAME_W-1:0] frame_w,
  input  logic [FRAME_W-1:0] frame_h,
  input  logic [PIX_W-1:0]   pix_col,
  input  logic [PIX_W-1:0]   pix_row,
  output logic               hit,
  output logic [PAL_W-1:0]   pal
);

  localparam logic signed [CRD_W-1:0] BW = CRD_W'(BORDER_WIDTH);

  box_t box_r;

  logic signed [CRD_W-1:0] w, h, c, r;
  logic signed [CRD_W-1:0] left, top, right, bottom;
  logic signed [CRD_W-1:0] x1, y1, x2, y2;
  logic                    h_band, v_band;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      box_r <= wr_box;
    end
  end

  always_comb begin
    w      = $signed({{(CRD_W-FRAME_W){1'b0}}, frame_w});
    h      = $signed({{(CRD_W-FRAME_W){1'b0}}, frame_h});
    c      = $signed({{(CRD_W-PIX_W){1'b0}}, pix_col});
    r      = $signed({{(CRD_W-PIX_W){1'b0}}, pix_row});
    left   = sx_coord(box_r.left);
    top    = sx_coord(box_r.top);
    right  = sx_coord(box_r.right);
    bottom = sx_coord(box_r.bottom);
    x1     = (left < 0) ? '0 : left;
    y1     = (top < 0) ? '0 : top;
    x2     = (right < w - 1) ? right : w - 1;
    y2     = (bottom < h - 1) ? bottom : h - 1;
    h_band = (c >= x1) && (c <= x2) && (r < h) &&
             (((r >= y1) && (r <= y1 + BW - 1)) || ((r >= y2 - BW + 1) && (r <= y2)));
    v_band = (r >= y1) && (r <= y2) && (c < w) &&
             (((c >= x1) && (c <= x1 + BW - 1)) || ((c >= x2 - BW + 1) && (c <= x2)));
  end

  assign hit = h_band || v_band;
  assign pal = box_r.pal;

endmodule

// ----- rtl/bbo_pick.sv -----
// Picks the color of the latest covering box, or passes the pixel through.
module bbo_pick import bbo_pkg::*; #(
  parameter int MAX_BOXES = 16
) (
  input  logic [MAX_BOXES-1:0]            hits,
  input  logic [MAX_BOXES-1:0][PAL_W-1:0] pals,
  input  color_t                          pix,
  output color_t                          color,
  output logic                            on_border
);

  logic [MAX_BOXES-1:0] last;
  color_t               box_color;

  // A hit counts only when no later entry also hits, so at most one bit is set.
  always_comb begin
    for (int i = 0; i < MAX_BOXES; i++) begin
      last[i] = hits[i] && ((hits >> (i + 1)) == '0);
    end
  end

  always_comb begin
    box_color = '0;
    for (int i = 0; i < MAX_BOXES; i++) begin
      box_color = box_color | (last[i] ? pal_color(pals[i]) : color_t'('0));
    end
  end

  assign on_border = |hits;
  assign color     = on_border ? box_color : pix;

endmodule

// ----- rtl/bounding_box_border_overlay.sv -----
// Top level of the bounding box border overlay.
//
//   channel   direction   words
//   in_ch     sink        clear, append box, or pixel with position and color
//   out_ch    source      overlaid pixel and on_border flag, one per pixel word
//   cfg_ch    sink        frame width (index 0) or frame height (index 1)
//
// One word per clock unless the output stalls; a pixel passes the s0, s1 and output registers.
// All box entries are compared against the pixel in parallel, one compare lane per entry.
// Reset empties the box table and sets the frame to 640 by 480; no clearing pass is needed.
// A stalled output holds its word while the input and middle stages keep filling.
// Configuration writes are always accepted.
module bounding_box_border_overlay import bbo_pkg::*; #(
  parameter int MAX_BOXES    = 16,
  parameter int BORDER_WIDTH = 2
) (
  input logic      clk,
  input logic      rst_n,
  bbo_in_if.sink   in_ch,
  bbo_out_if.source out_ch,
  bbo_cfg_if.sink  cfg_ch
);

  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

  logic [FRAME_W-1:0] fw_r, fh_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  in_item_t s0_r;
  logic     s0_v_r;
  logic     s1_v_r;
  logic     out_v_r;

  logic [MAX_BOXES-1:0]            s1_hit_r;
  logic [MAX_BOXES-1:0][PAL_W-1:0] s1_pal_r;
  color_t                          s1_pix_r;
  color_t                          out_col_r;
  logic                            out_hit_r;

  logic                            out_ld, s1_ld, s0_adv, in_acc, append_en;
  logic [MAX_BOXES-1:0]            lane_hit, lane_we, act_hit;
  logic [MAX_BOXES-1:0][PAL_W-1:0] lane_pal;
  box_t                            new_box;
  color_t                          pick_col;
  logic                            pick_hit;

  assign out_ld = !out_v_r || out_ch.ready;
  assign s1_ld  = !s1_v_r || out_ld;
  assign s0_adv = s0_v_r && ((s0_r.mode != MODE_PIXEL) || s1_ld);
  assign in_ch.ready = !s0_v_r || s0_adv;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FRAME_WIDTH_RST;
      fh_r <= FRAME_HEIGHT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_FRAME_WIDTH:  fw_r <= cfg_ch.data;
        CFG_FRAME_HEIGHT: fh_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_r.mode         <= in_ch.mode;
      s0_r.box_left     <= in_ch.box_left;
      s0_r.box_top      <= in_ch.box_top;
      s0_r.box_right    <= in_ch.box_right;
      s0_r.box_bottom   <= in_ch.box_bottom;
      s0_r.class_number <= in_ch.class_number;
      s0_r.pixel_col    <= in_ch.pixel_col;
      s0_r.pixel_row    <= in_ch.pixel_row;
      s0_r.pix          <= '{blue: in_ch.in_blue, green: in_ch.in_green, red: in_ch.in_red};
    end
  end

  // The table changes only as a command word leaves the first stage, so every
  // pixel is compared against exactly the boxes stored before it.
  always_comb begin
    cnt_nxt   = cnt_r;
    append_en = 1'b0;
    if (s0_adv) begin
      unique case (s0_r.mode)
        MODE_CLEAR: cnt_nxt = '0;
        MODE_APPEND: begin
          if (cnt_r < CNT_W'(MAX_BOXES)) begin
            append_en = 1'b1;
            cnt_nxt   = cnt_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_ch.ready) begin
        s0_v_r <= in_ch.valid;
      end
      if (s1_ld) begin
        s1_v_r <= s0_adv && (s0_r.mode == MODE_PIXEL);
      end
      if (out_ld) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  assign new_box = '{left:   s0_r.box_left,
                     top:    s0_r.box_top,
                     right:  s0_r.box_right,
                     bottom: s0_r.box_bottom,
                     pal:    pal_index(s0_r.class_number)};

  for (genvar g = 0; g < MAX_BOXES; g++) begin : g_lane
    assign lane_we[g] = append_en && (cnt_r[IDX_W-1:0] == IDX_W'(g));
    assign act_hit[g] = lane_hit[g] && (CNT_W'(g) < cnt_r);

    bbo_box_lane #(
      .BORDER_WIDTH(BORDER_WIDTH)
    ) u_lane (
      .clk     (clk),
      .wr_en   (lane_we[g]),
      .wr_box  (new_box),
      .frame_w (fw_r),
      .frame_h (fh_r),
      .pix_col (s0_r.pixel_col),
      .pix_row (s0_r.pixel_row),
      .hit     (lane_hit[g]),
      .pal     (lane_pal[g])
    );
  end

  always_ff @(posedge clk) begin
    if (s1_ld) begin
      s1_hit_r <= act_hit;
      s1_pal_r <= lane_pal;
      s1_pix_r <= s0_r.pix;
    end
  end

  bbo_pick #(
    .MAX_BOXES(MAX_BOXES)
  ) u_pick (
    .hits      (s1_hit_r),
    .pals      (s1_pal_r),
    .pix       (s1_pix_r),
    .color     (pick_col),
    .on_border (pick_hit)
  );

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_col_r <= pick_col;
      out_hit_r <= pick_hit;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.out_blue  = out_col_r.blue;
  assign out_ch.out_green = out_col_r.green;
  assign out_ch.out_red   = out_col_r.red;
  assign out_ch.on_border = out_hit_r;

endmodule

// ----- rtl/bbo_checker.sv -----
// Port-level assertions for the bounding box border overlay, bound to the top level.
module bbo_checker import bbo_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic [1:0]      in_mode,
  input logic            out_valid,
  input logic            out_ready,
  input logic [CH_W-1:0] out_blue,
  input logic [CH_W-1:0] out_green,
  input logic [CH_W-1:0] out_red,
  input logic            on_border
);

  logic [2:0] pend_r;
  logic       pix_in, word_out;
  color_t     col;

  assign pix_in   = in_valid && in_ready && (in_mode == MODE_PIXEL);
  assign word_out = out_valid && out_ready;
  assign col      = '{blue: out_blue, green: out_green, red: out_red};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {2'd0, pix_in} - {2'd0, word_out};
    end
  end

  a_no_extra_word: assert property (@(posedge clk) disable iff (!rst_n)
    word_out |-> (pend_r != 3'd0))
    else $error("output word without a pending pixel");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd3)
    else $error("more pixels in flight than pipeline stages");

  a_border_color: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && on_border) |->
      (col == PAL_GREEN || col == PAL_RED || col == PAL_BLUE ||
       col == PAL_YELLOW || col == PAL_MAGENTA || col == PAL_CYAN))
    else $error("border pixel not a palette color");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(col) && $stable(on_border)))
    else $error("stalled output word changed");

endmodule

bind bounding_box_border_overlay bbo_checker u_bbo_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_mode   (in_ch.mode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_blue  (out_ch.out_blue),
  .out_green (out_ch.out_green),
  .out_red   (out_ch.out_red),
  .on_border (out_ch.on_border)
);
